// ===== src/ptt_pkg.sv =====
`default_nettype none

package ptt_pkg;

    localparam int KEY_W    = 64;
    localparam int PRIO_W   = 16;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 3;

    // request action codes
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LIST   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd5;

    typedef struct packed {
        logic                     valid;
        logic [KEY_W-1:0]         key;
        logic signed [PRIO_W-1:0] prio;
    } t_entry;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_COMPARE,
        OP_INSERT,
        OP_REMOVE,
        OP_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                 op;
        logic [KEY_W-1:0]         key;
        logic signed [PRIO_W-1:0] prio;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LIST
    } t_state;

endpackage

`default_nettype wire

// ===== src/ptt_cell.sv =====
`default_nettype none

module ptt_cell import ptt_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire t_entry    i_left,
    input  wire logic      i_left_cond,
    input  wire t_entry    i_right,
    input  wire logic      i_gone,
    output t_entry         o_entry,
    output logic           o_cond,
    output logic           o_match,
    output logic           o_gone
);

    logic                     r_valid;
    logic [KEY_W-1:0]         r_key;
    logic signed [PRIO_W-1:0] r_prio;
    logic                     r_match;
    logic                     r_cond;

    logic                     n_valid;
    logic [KEY_W-1:0]         n_key;
    logic signed [PRIO_W-1:0] n_prio;
    logic                     n_match;
    logic                     n_cond;

    // match at this cell or at any cell ahead of it
    assign o_gone  = r_match | i_gone;
    assign o_cond  = r_cond;
    assign o_match = r_match;
    assign o_entry = '{valid: r_valid, key: r_key, prio: r_prio};

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_prio  = r_prio;
        n_match = r_match;
        n_cond  = r_cond;
        case (i_ctl.op)
            OP_COMPARE: begin
                n_match = r_valid && (r_key == i_ctl.key);
                n_cond  = !r_valid || ($signed(r_prio) <= $signed(i_ctl.prio));
            end
            OP_INSERT: begin
                if (r_cond) begin
                    if (i_left_cond) begin
                        n_valid = i_left.valid;
                        n_key   = i_left.key;
                        n_prio  = i_left.prio;
                    end else begin
                        n_valid = 1'b1;
                        n_key   = i_ctl.key;
                        n_prio  = i_ctl.prio;
                    end
                end
            end
            OP_REMOVE: begin
                if (o_gone) begin
                    n_valid = i_right.valid;
                    n_key   = i_right.key;
                    n_prio  = i_right.prio;
                end
            end
            OP_ROTATE: begin
                n_valid = i_right.valid;
                n_key   = i_right.key;
                n_prio  = i_right.prio;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
            r_cond  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_match <= n_match;
            r_cond  <= n_cond;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_prio <= n_prio;
    end

endmodule

`default_nettype wire

// ===== src/priority_task_table.sv =====
// priority_task_table: bounded table of unique 64-bit keys, each with a signed
// 16-bit priority, kept in a row of cells ordered by priority descending and,
// among equal priorities, newest first
// input channel: i_in_valid / o_in_ready carry one request (action, key,
// priority_req, threshold); output channel: o_out_valid / i_out_ready carry
// one result (status, entry_key, entry_priority, last)
// insert and remove: the accept edge latches the key and priority compare
// flags in every cell; once the result register is free, the row shifts by
// one cell in parallel and the result register is written
// a list request rotates the whole row through cell 0, one cell per cycle
// while the receiver does not stall, emitting qualifying entries; when it
// ends, the row is back in its original order
// unused action code 3 is accepted and produces no result
// reset (synchronous, active low) empties the table and the result register;
// no clearing pass is needed
// when the receiver stalls, the pending result holds and the row stops
// shifting; a new request is taken only while no request is in progress
`default_nettype none

module priority_task_table import ptt_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [ACTION_W-1:0]      i_action,
    input  wire logic [KEY_W-1:0]         i_key,
    input  wire logic signed [PRIO_W-1:0] i_priority_req,
    input  wire logic signed [PRIO_W-1:0] i_threshold,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [STATUS_W-1:0]           o_status,
    output logic [KEY_W-1:0]              o_entry_key,
    output logic signed [PRIO_W-1:0]      o_entry_priority,
    output logic                          o_last
);

    localparam int STEP_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DEPTH - 1);

    // cell row interconnect
    t_entry     w_entry [DEPTH];
    logic       w_cond  [DEPTH];
    logic       w_gone  [DEPTH];
    logic [DEPTH-1:0] w_match;
    logic [DEPTH-1:0] w_valid;
    t_cell_ctl  w_ctl;

    // control state
    t_state                   r_state;
    t_state                   n_state;
    logic [ACTION_W-1:0]      r_action;
    logic [KEY_W-1:0]         r_key;
    logic signed [PRIO_W-1:0] r_prio;
    logic signed [PRIO_W-1:0] r_thr;
    logic [STEP_W-1:0]        r_step;
    logic                     r_run;

    // result register
    logic                     r_out_valid;
    logic [STATUS_W-1:0]      r_out_status;
    logic [KEY_W-1:0]         r_out_key;
    logic signed [PRIO_W-1:0] r_out_prio;
    logic                     r_out_last;

    logic                     w_accept;
    logic                     w_out_free;
    logic                     w_any_match;
    logic                     w_full;
    logic                     w_head_ok;
    logic                     w_next_ok;
    t_entry                   w_next;

    // result to be loaded this cycle
    logic                     w_emit;
    logic [STATUS_W-1:0]      w_emit_status;
    logic [KEY_W-1:0]         w_emit_key;
    logic signed [PRIO_W-1:0] w_emit_prio;
    logic                     w_emit_last;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_any_match = |w_match;
    assign w_full      = w_valid[DEPTH-1];

    // list: cell 0 holds the entry at the current step, cell 1 the one after it
    assign w_next    = (DEPTH > 1) ? w_entry[1 % DEPTH] : '0;
    assign w_head_ok = w_entry[0].valid && ($signed(w_entry[0].prio) >= $signed(r_thr));
    assign w_next_ok = (r_step != LAST_STEP) && w_next.valid
                       && ($signed(w_next.prio) >= $signed(r_thr));

    // the row of cells
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_cond;
        logic   w_gone_in;

        if (gi == 0) begin : g_head
            assign w_left      = '0;
            assign w_left_cond = 1'b0;
            assign w_gone_in   = 1'b0;
        end else begin : g_body
            assign w_left      = w_entry[gi-1];
            assign w_left_cond = w_cond[gi-1];
            assign w_gone_in   = w_gone[gi-1];
        end

        // the tail wraps to the head only while rotating for a list
        if (gi == DEPTH - 1) begin : g_tail
            assign w_right = (w_ctl.op == OP_ROTATE) ? w_entry[0] : '0;
        end else begin : g_mid
            assign w_right = w_entry[gi+1];
        end

        ptt_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_left      (w_left),
            .i_left_cond (w_left_cond),
            .i_right     (w_right),
            .i_gone      (w_gone_in),
            .o_entry     (w_entry[gi]),
            .o_cond      (w_cond[gi]),
            .o_match     (w_match[gi]),
            .o_gone      (w_gone[gi])
        );

        assign w_valid[gi] = w_entry[gi].valid;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_action == ACT_INSERT || i_action == ACT_REMOVE) begin
                        n_state = S_EXEC;
                    end else if (i_action == ACT_LIST) begin
                        n_state = S_LIST;
                    end
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                if (w_out_free && r_step == LAST_STEP) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs: cell command and result
    always_comb begin
        o_in_ready    = 1'b0;
        w_ctl.op      = OP_HOLD;
        // the held request drives the row after the accept edge
        w_ctl.key     = r_key;
        w_ctl.prio    = r_prio;
        w_emit        = 1'b0;
        w_emit_status = ST_DONE;
        w_emit_key    = '0;
        w_emit_prio   = '0;
        w_emit_last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                w_ctl.key  = i_key;
                w_ctl.prio = i_priority_req;
                // compare flags latched in every cell at the accept edge
                if (w_accept) begin
                    w_ctl.op = OP_COMPARE;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    if (r_action == ACT_INSERT) begin
                        if (w_full) begin
                            w_emit_status = ST_FULL;
                        end else if (w_any_match) begin
                            w_emit_status = ST_DUPLICATE;
                        end else begin
                            w_emit_status = ST_DONE;
                            w_ctl.op      = OP_INSERT;
                        end
                    end else begin
                        if (w_any_match) begin
                            w_emit_status = ST_DONE;
                            w_ctl.op      = OP_REMOVE;
                        end else begin
                            w_emit_status = ST_NOT_FOUND;
                        end
                    end
                end
            end
            S_LIST: begin
                if (w_out_free) begin
                    w_ctl.op = OP_ROTATE;
                    if (r_run && w_head_ok) begin
                        w_emit        = 1'b1;
                        w_emit_status = ST_LISTED;
                        w_emit_key    = w_entry[0].key;
                        w_emit_prio   = w_entry[0].prio;
                        w_emit_last   = !w_next_ok;
                    end else if (r_run && r_step == '0) begin
                        // nothing qualifies at the head of the table
                        w_emit        = 1'b1;
                        w_emit_status = ST_NONE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_run       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_free) begin
                r_out_valid <= w_emit;
            end
            if (r_state == S_IDLE) begin
                r_step <= '0;
                r_run  <= 1'b1;
            end else if (r_state == S_LIST && w_out_free) begin
                r_step <= r_step + 1'b1;
                if (!w_head_ok) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_action;
            r_key    <= i_key;
            r_prio   <= i_priority_req;
            r_thr    <= i_threshold;
        end
        if (w_out_free && w_emit) begin
            r_out_status <= w_emit_status;
            r_out_key    <= w_emit_key;
            r_out_prio   <= w_emit_prio;
            r_out_last   <= w_emit_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_entry_key      = r_out_key;
    assign o_entry_priority = r_out_prio;
    assign o_last           = r_out_last;

`ifndef NO_ASSERTIONS
    // outside a list rotation the occupied cells form an unbroken run from cell 0
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LIST) |->
            ((({1'b0, w_valid} + 1'b1) & {1'b0, w_valid}) == '0))
        else $error("occupied cells are not contiguous");

    // a successful insert adds exactly one entry
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op == OP_INSERT) |=>
            ($countones(w_valid) == $past($countones(w_valid)) + 1))
        else $error("insert did not add one entry");

    // a successful remove drops exactly one entry
    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op == OP_REMOVE) |=>
            ($countones(w_valid) + 1 == $past($countones(w_valid))))
        else $error("remove did not drop one entry");

    // every rotation step leaves the table size unchanged
    a_list_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op == OP_ROTATE) |=>
            ($countones(w_valid) == $past($countones(w_valid))))
        else $error("list rotation changed the table size");
`endif

endmodule

`default_nettype wire
